// ===== hw/rtl/command_frame_encoder_macros.svh =====
// assertion macros used by the command frame encoder serializer
// expects a clock i_clk and an active-low reset i_rst_n in the including module
`ifndef COMMAND_FRAME_ENCODER_MACROS_SVH
`define COMMAND_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cfe_pkg.sv =====
// shared types and constants of the command frame encoder
// no dependencies
`timescale 1ns / 1ps

package cfe_pkg;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_ROBOT_ID   = 3'd0;
    localparam logic [2:0] REG_MOVE_CODE  = 3'd1;
    localparam logic [2:0] REG_WATER_CODE = 3'd2;
    localparam logic [2:0] REG_BRUSH_CODE = 3'd3;
    localparam logic [2:0] REG_STOP_CODE  = 3'd4;

    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_WATER = 2'd1;
    localparam logic [1:0] ACT_BRUSH = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam logic [7:0]  MOVE_LEN  = 8'h06;
    localparam logic [7:0]  SHORT_LEN = 8'h03;
    localparam logic [14:0] MAG_MAX   = 15'h7FFF;

    localparam logic [2:0] MOVE_LAST_IDX  = 3'd7;
    localparam logic [2:0] SHORT_LAST_IDX = 3'd4;

    typedef struct packed {
        logic [7:0] robot_id;
        logic [7:0] move_code;
        logic [7:0] water_code;
        logic [7:0] brush_code;
        logic [7:0] stop_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      last_idx;
    } t_frame;

endpackage

// ===== hw/rtl/command_frame_encoder.sv =====
// command frame encoder: command requests in, frame bytes out
// channels: input command request (i_valid / o_stall), output byte request
//   (o_valid / i_stall), apb port for robot id and the four command codes
// each accepted command becomes one frame: id, length, code, payload, checksum;
//   move frames are 8 bytes, water, brush and stop frames 5 bytes
// o_last_byte is high on the checksum byte that closes a frame
// an accepted command is held in the frame buffer until the byte shifter is free
// throughput: one byte per cycle when not stalled, set by the byte shifter; one
//   more command waits in the frame buffer while the current frame shifts out
// a stall on the output holds the current byte; once the frame buffer is full,
//   o_stall rises until the shifter takes the next frame
// reset (synchronous, active low) empties both stages and zeroes the
//   configuration, valid flags and byte count, but not the frame data
// configuration is to be written by the user only while no frame is pending;
//   the block itself does not enforce this
// depends on cfe_pkg, cfe_regs, cfe_builder, cfe_serializer
`timescale 1ns / 1ps

module command_frame_encoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cfe_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_action,
    input  logic signed [15:0]        i_right_speed,
    input  logic signed [15:0]        i_left_speed,
    input  logic                      i_switch_on,
    input  logic [7:0]                i_brush_level,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_tx_byte,
    output logic                      o_last_byte
);
    import cfe_pkg::*;

    t_cfg   w_cfg;
    t_frame w_frame;
    logic   w_frame_valid;
    logic   w_take;

    cfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cfe_builder u_builder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_right_speed (i_right_speed),
        .i_left_speed  (i_left_speed),
        .i_switch_on   (i_switch_on),
        .i_brush_level (i_brush_level),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame),
        .i_take        (w_take)
    );

    cfe_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_frame_valid),
        .i_frame       (w_frame),
        .o_take        (w_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

// ===== hw/rtl/cfe_regs.sv =====
// apb configuration registers: robot id and the four command codes
// depends on cfe_pkg
`timescale 1ns / 1ps

module cfe_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cfe_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output cfe_pkg::t_cfg             o_cfg
);
    import cfe_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;
    logic [7:0] w_rd;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROBOT_ID:   r_cfg.robot_id   <= pwdata[7:0];
                REG_MOVE_CODE:  r_cfg.move_code  <= pwdata[7:0];
                REG_WATER_CODE: r_cfg.water_code <= pwdata[7:0];
                REG_BRUSH_CODE: r_cfg.brush_code <= pwdata[7:0];
                REG_STOP_CODE:  r_cfg.stop_code  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROBOT_ID:   w_rd = r_cfg.robot_id;
            REG_MOVE_CODE:  w_rd = r_cfg.move_code;
            REG_WATER_CODE: w_rd = r_cfg.water_code;
            REG_BRUSH_CODE: w_rd = r_cfg.brush_code;
            REG_STOP_CODE:  w_rd = r_cfg.stop_code;
            default:        w_rd = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, w_rd};

endmodule

// ===== hw/rtl/cfe_builder.sv =====
// builds a whole frame with checksum from one command request into a frame buffer
// depends on cfe_pkg
`timescale 1ns / 1ps

module cfe_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfe_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_action,
    input  logic signed [15:0]  i_right_speed,
    input  logic signed [15:0]  i_left_speed,
    input  logic                i_switch_on,
    input  logic [7:0]          i_brush_level,
    output logic                o_frame_valid,
    output cfe_pkg::t_frame     o_frame,
    input  logic                i_take
);
    import cfe_pkg::*;

    // sign-magnitude with saturation, {hi, lo}
    function automatic logic [15:0] speed_bytes(input logic [15:0] v);
        logic        neg;
        logic [15:0] mag;
        neg = v[15];
        mag = neg ? (~v + 16'd1) : v;
        if (mag[15]) begin
            mag = {1'b0, MAG_MAX};
        end
        return {neg, mag[14:8], mag[7:0]};
    endfunction

    logic            r_valid;
    t_frame          r_frame;
    t_frame          n_frame;
    logic            w_accept;
    logic [15:0]     w_right;
    logic [15:0]     w_left;
    logic [7:0]      w_sum;
    logic [7:0]      w_chk;

    assign o_stall       = r_valid && !i_take;
    assign w_accept      = i_valid && !o_stall;
    assign o_frame_valid = r_valid;
    assign o_frame       = r_frame;

    assign w_right = speed_bytes(i_right_speed);
    assign w_left  = speed_bytes(i_left_speed);

    always_comb begin
        n_frame          = '0;
        n_frame.bytes[0] = i_cfg.robot_id;
        unique case (i_action)
            ACT_MOVE: begin
                n_frame.bytes[1] = MOVE_LEN;
                n_frame.bytes[2] = i_cfg.move_code;
                n_frame.bytes[3] = w_right[15:8];
                n_frame.bytes[4] = w_right[7:0];
                n_frame.bytes[5] = w_left[15:8];
                n_frame.bytes[6] = w_left[7:0];
                n_frame.last_idx = MOVE_LAST_IDX;
            end
            ACT_WATER: begin
                n_frame.bytes[1] = SHORT_LEN;
                n_frame.bytes[2] = i_cfg.water_code;
                n_frame.bytes[3] = {7'd0, i_switch_on};
                n_frame.last_idx = SHORT_LAST_IDX;
            end
            ACT_BRUSH: begin
                n_frame.bytes[1] = SHORT_LEN;
                n_frame.bytes[2] = i_cfg.brush_code;
                n_frame.bytes[3] = i_brush_level;
                n_frame.last_idx = SHORT_LAST_IDX;
            end
            ACT_STOP: begin
                n_frame.bytes[1] = SHORT_LEN;
                n_frame.bytes[2] = i_cfg.stop_code;
                n_frame.bytes[3] = {7'd0, i_switch_on};
                n_frame.last_idx = SHORT_LAST_IDX;
            end
            default: ;
        endcase
        // bytes past the payload are zero on short frames, so one sum covers both
        w_sum = n_frame.bytes[0] + n_frame.bytes[1] + n_frame.bytes[2] + n_frame.bytes[3]
              + n_frame.bytes[4] + n_frame.bytes[5] + n_frame.bytes[6];
        w_chk = ~w_sum + 8'd1;
        n_frame.bytes[n_frame.last_idx] = w_chk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame <= n_frame;
        end
    end

endmodule

// ===== hw/rtl/cfe_serializer.sv =====
// shifts a buffered frame out one byte per request and flags the checksum byte
// depends on cfe_pkg and command_frame_encoder_macros.svh
`timescale 1ns / 1ps
`include "command_frame_encoder_macros.svh"

module cfe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_frame_valid,
    input  cfe_pkg::t_frame i_frame,
    output logic            o_take,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_tx_byte,
    output logic            o_last_byte
);
    import cfe_pkg::*;

    logic            r_valid;
    logic [7:0][7:0] r_bytes;
    logic [2:0]      r_left;
    logic            w_load;
    logic            w_out_acc;
    logic            w_at_last;

    assign w_at_last = (r_left == 3'd0);
    assign w_out_acc = r_valid && !i_stall;
    assign o_take    = !r_valid || (w_out_acc && w_at_last);
    assign w_load    = i_frame_valid && o_take;

    assign o_valid     = r_valid;
    assign o_tx_byte   = r_bytes[0];
    assign o_last_byte = w_at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 3'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_left  <= i_frame.last_idx;
        end else if (w_out_acc) begin
            r_left <= r_left - 3'd1;
            if (w_at_last) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bytes <= i_frame.bytes;
        end else if (w_out_acc) begin
            r_bytes <= {8'h00, r_bytes[7:1]};
        end
    end

    `CFE_ASSERT_NEXT(a_no_cut, w_out_acc && !w_at_last, r_valid, "frame cut short")
    `CFE_ASSERT_NEXT(a_count_down, w_out_acc && !w_at_last,
        r_left == $past(r_left) - 3'd1, "byte count skipped")
    `CFE_ASSERT_NEXT(a_load_len, w_load,
        r_valid && (r_left == $past(i_frame.last_idx)), "frame length not loaded")
    `CFE_ASSERT_NOW(a_take_free, w_load && r_valid, w_at_last && !i_stall,
        "frame loaded over busy shifter")

endmodule

// ===== tb/sv/command_frame_encoder_test.sv =====
// self-checking testbench for command_frame_encoder: commands go in, frame bytes are
// predicted from a shadow of the code registers and checked in order at the output
// depends on cfe_pkg and the command_frame_encoder rtl
`timescale 1ns / 1ps

module command_frame_encoder_test;

    import cfe_pkg::*;

    localparam string PASS_MSG = "** command_frame_encoder: PASSED **";
    localparam string FAIL_MSG = "** command_frame_encoder: FAILED **";

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 50;

    typedef enum {RX_FREE, RX_RANDOM, RX_BURSTY, RX_HOLD} t_rx_mode;

    typedef struct {
        logic [1:0]         action;
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
        logic               switch_on;
        logic [7:0]         brush_level;
    } t_command;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_AW-1:0]         paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_valid;
    logic                      o_stall;
    logic [1:0]                i_action;
    logic signed [15:0]        i_right_speed;
    logic signed [15:0]        i_left_speed;
    logic                      i_switch_on;
    logic [7:0]                i_brush_level;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [7:0]                o_tx_byte;
    logic                      o_last_byte;

    t_cfg        code_shadow = '0;
    t_frame_byte frame_bytes_due[$];
    t_rx_mode    rx_mode = RX_FREE;
    int          rx_hold_count = 0;
    int          rx_run_left = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    command_frame_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_right_speed (i_right_speed),
        .i_left_speed  (i_left_speed),
        .i_switch_on   (i_switch_on),
        .i_brush_level (i_brush_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    function automatic logic [15:0] sign_magnitude(input logic signed [15:0] speed);
        logic [16:0] mag;
        mag = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
        if (mag > {2'b00, MAG_MAX}) begin
            mag = {2'b00, MAG_MAX};
        end
        return {speed[15], mag[14:0]};
    endfunction

    function automatic void encode_frame(input t_command cmd);
        logic [7:0]  fb[8];
        logic [7:0]  sum;
        logic [15:0] right_sm;
        logic [15:0] left_sm;
        int          n;
        fb = '{default: 8'h00};
        right_sm = sign_magnitude(cmd.right_speed);
        left_sm = sign_magnitude(cmd.left_speed);
        fb[0] = code_shadow.robot_id;
        case (cmd.action)
            ACT_MOVE: begin
                fb[1] = MOVE_LEN;
                fb[2] = code_shadow.move_code;
                fb[3] = right_sm[15:8];
                fb[4] = right_sm[7:0];
                fb[5] = left_sm[15:8];
                fb[6] = left_sm[7:0];
            end
            ACT_WATER: begin
                fb[1] = SHORT_LEN;
                fb[2] = code_shadow.water_code;
                fb[3] = {7'b0, cmd.switch_on};
            end
            ACT_BRUSH: begin
                fb[1] = SHORT_LEN;
                fb[2] = code_shadow.brush_code;
                fb[3] = cmd.brush_level;
            end
            ACT_STOP: begin
                fb[1] = SHORT_LEN;
                fb[2] = code_shadow.stop_code;
                fb[3] = {7'b0, cmd.switch_on};
            end
        endcase
        n = int'(fb[1]) + 2;
        sum = 8'h00;
        for (int i = 0; i < n - 1; i++) begin
            sum = sum + fb[i];
        end
        fb[n - 1] = ~sum + 8'd1;
        for (int i = 0; i < n; i++) begin
            frame_bytes_due.push_back('{data: fb[i], last: (i == n - 1)});
        end
    endfunction

    function automatic t_command make_cmd(input logic [1:0] action, input int right_speed,
                                          input int left_speed, input logic switch_on,
                                          input logic [7:0] brush_level);
        t_command cmd;
        cmd.action = action;
        cmd.right_speed = 16'(right_speed);
        cmd.left_speed = 16'(left_speed);
        cmd.switch_on = switch_on;
        cmd.brush_level = brush_level;
        return cmd;
    endfunction

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return -16'sd32767;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_command random_cmd();
        t_command cmd;
        cmd.action = 2'($urandom_range(0, 3));
        cmd.right_speed = pick_speed();
        cmd.left_speed = pick_speed();
        cmd.switch_on = 1'($urandom);
        cmd.brush_level = 8'($urandom);
        return cmd;
    endfunction

    // leaves i_valid high so the next request can follow back to back
    task automatic send_cmd(input t_command cmd);
        i_valid <= 1'b1;
        i_action <= cmd.action;
        i_right_speed <= cmd.right_speed;
        i_left_speed <= cmd.left_speed;
        i_switch_on <= cmd.switch_on;
        i_brush_level <= cmd.brush_level;
        do @(posedge i_clk); while (o_stall);
        encode_frame(cmd);
    endtask

    task automatic wait_frames_done();
        i_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00});
        pwdata <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== value) begin
            report_mismatch("register readback", int'(prdata[7:0]), int'(value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ROBOT_ID:   code_shadow.robot_id = value;
            REG_MOVE_CODE:  code_shadow.move_code = value;
            REG_WATER_CODE: code_shadow.water_code = value;
            REG_BRUSH_CODE: code_shadow.brush_code = value;
            REG_STOP_CODE:  code_shadow.stop_code = value;
            default: ;
        endcase
    endtask

    task automatic load_codes(input logic [7:0] robot_id, input logic [7:0] move_code,
                              input logic [7:0] water_code, input logic [7:0] brush_code,
                              input logic [7:0] stop_code);
        set_register(REG_ROBOT_ID, robot_id);
        set_register(REG_MOVE_CODE, move_code);
        set_register(REG_WATER_CODE, water_code);
        set_register(REG_BRUSH_CODE, brush_code);
        set_register(REG_STOP_CODE, stop_code);
    endtask

    // registers still at their reset value of zero
    task automatic test_reset_values();
        send_cmd(make_cmd(ACT_MOVE, 1000, -1000, 1'b1, 8'h5A));
        send_cmd(make_cmd(ACT_WATER, 0, 0, 1'b1, 8'h00));
        send_cmd(make_cmd(ACT_BRUSH, -5, 7, 1'b0, 8'h80));
        send_cmd(make_cmd(ACT_STOP, 0, 0, 1'b1, 8'hFF));
        wait_frames_done();
    endtask

    task automatic test_directed_frames();
        load_codes(8'h42, 8'h10, 8'h21, 8'h32, 8'h43);
        send_cmd(make_cmd(ACT_MOVE, 0, 0, 1'b0, 8'h00));
        send_cmd(make_cmd(ACT_MOVE, 32767, -32767, 1'b0, 8'h00));
        // most negative speed saturates to full magnitude
        send_cmd(make_cmd(ACT_MOVE, -32768, -32768, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_MOVE, -1, 1, 1'b0, 8'h00));
        send_cmd(make_cmd(ACT_MOVE, -32768, 32767, 1'b1, 8'h11));
        send_cmd(make_cmd(ACT_MOVE, 255, -256, 1'b0, 8'h00));
        // unused fields carry junk
        send_cmd(make_cmd(ACT_WATER, -32768, 32767, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_WATER, 12345, -12345, 1'b0, 8'hAA));
        send_cmd(make_cmd(ACT_BRUSH, -1, -1, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_BRUSH, 32767, 0, 1'b0, 8'h00));
        send_cmd(make_cmd(ACT_BRUSH, 0, -32768, 1'b1, 8'hA5));
        send_cmd(make_cmd(ACT_STOP, -32768, -32768, 1'b1, 8'h55));
        send_cmd(make_cmd(ACT_STOP, 1, 1, 1'b0, 8'hFF));
        wait_frames_done();
    endtask

    task automatic test_all_ones_codes();
        load_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(make_cmd(ACT_MOVE, -32768, 32767, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_WATER, 0, 0, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_BRUSH, 0, 0, 1'b1, 8'hFF));
        send_cmd(make_cmd(ACT_STOP, 0, 0, 1'b0, 8'hFF));
        wait_frames_done();
    endtask

    // output held off long enough for the input side to back up
    task automatic test_backpressure();
        load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        rx_mode <= RX_HOLD;
        for (int k = 0; k < 16; k++) begin
            send_cmd(random_cmd());
        end
        wait_frames_done();
        rx_mode <= RX_FREE;
        @(posedge i_clk);
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        int gap;
        for (int phase = 0; phase < 6; phase++) begin
            load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom));
            if (phase == 0) begin
                rx_mode <= RX_FREE;
            end else if (phase % 2 == 1) begin
                rx_mode <= RX_RANDOM;
            end else begin
                rx_mode <= RX_BURSTY;
            end
            sent = 0;
            while (sent < 45) begin
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < 45; k++) begin
                    send_cmd(random_cmd());
                    sent++;
                end
                gap = (phase == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            wait_frames_done();
        end
        rx_mode <= RX_FREE;
    endtask

    always @(posedge i_clk) begin
        if (rx_mode == RX_HOLD) begin
            rx_run_left <= 0;
            if (rx_hold_count < HOLD_CYCLES) begin
                i_stall <= 1'b1;
                rx_hold_count <= rx_hold_count + 1;
            end else begin
                i_stall <= 1'b0;
            end
        end else begin
            rx_hold_count <= 0;
            case (rx_mode)
                RX_RANDOM: i_stall <= ($urandom_range(0, 99) < 35);
                RX_BURSTY: begin
                    if (rx_run_left == 0) begin
                        i_stall <= ~i_stall;
                        rx_run_left <= i_stall ? $urandom_range(1, 10) : $urandom_range(1, 5);
                    end else begin
                        rx_run_left <= rx_run_left - 1;
                    end
                end
                default: i_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_frame_byte due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("unexpected frame byte", int'(o_tx_byte), 0);
            end else begin
                due = frame_bytes_due.pop_front();
                if (o_tx_byte !== due.data) begin
                    report_mismatch("tx_byte", int'(o_tx_byte), int'(due.data));
                end
                if (o_last_byte !== due.last) begin
                    report_mismatch("last_byte", int'(o_last_byte), int'(due.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display(FAIL_MSG);
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_action = ACT_MOVE;
        i_right_speed = '0;
        i_left_speed = '0;
        i_switch_on = 1'b0;
        i_brush_level = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed_frames();
        test_all_ones_codes();
        test_backpressure();
        test_random_traffic();
        wait_frames_done();
        if (mismatches == 0) begin
            $display(PASS_MSG);
        end else begin
            $display(FAIL_MSG);
        end
        $finish;
    end

endmodule
